### rtl/kvlt_pkg.sv
package kvlt_pkg;

  // Fixed payload widths of the request and response beats
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 48;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 6;

  // Request modes; the unused code behaves as a lookup
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Response status codes
  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  // Scan outcome flags handed from the scan unit to the sequencer
  typedef struct packed {
    logic done;
    logic hit;
    logic free_ok;
  } scan_flags_t;

endpackage

### rtl/kvlt_if.sv
// Request channel
interface kvlt_req_if;
  logic                             valid;
  logic                             ready;
  logic [kvlt_pkg::MODE_W-1:0]      mode;
  logic [kvlt_pkg::KEY_W-1:0]       key;
  logic [kvlt_pkg::VALUE_W-1:0]     value_in;

  modport source (output valid, output mode, output key, output value_in, input ready);
  modport sink   (input valid, input mode, input key, input value_in, output ready);
endinterface

// Response channel
interface kvlt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [kvlt_pkg::SLOT_W-1:0]      slot;
  logic [kvlt_pkg::VALUE_W-1:0]     value_out;
  logic [kvlt_pkg::STAT_W-1:0]      status;
  logic [kvlt_pkg::COUNT_W-1:0]     entry_count;

  modport source (output valid, output found, output slot, output value_out,
                  output status, output entry_count, input ready);
  modport sink   (input valid, input found, input slot, input value_out,
                  input status, input entry_count, output ready);
endinterface

### rtl/kvlt_store.sv
// Key and value slot memories: one write port, one registered read port
module kvlt_store #(
  parameter int unsigned ENTRIES    = 40,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 48,
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  key_we_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  logic [KEY_BITS-1:0]   wkey_i,
  input  logic [VALUE_BITS-1:0] wval_i,
  input  logic                  re_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output logic [KEY_BITS-1:0]   rkey_o,
  output logic [VALUE_BITS-1:0] rval_o
);

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [KEY_BITS-1:0]   rkey_q;
  logic [VALUE_BITS-1:0] rval_q;

  // write port; the key is written only when a new slot is filled
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      if (key_we_i) begin
        key_mem[waddr_i] <= wkey_i;
      end
      val_mem[waddr_i] <= wval_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_q <= key_mem[raddr_i];
      rval_q <= val_mem[raddr_i];
    end
  end

  assign rkey_o = rkey_q;
  assign rval_o = rval_q;

endmodule

### rtl/kvlt_scan.sv
// Slot scanner: walks the slots one per cycle through the memory read port
// and a single key comparator, keeping the lowest match and lowest free slot.
module kvlt_scan #(
  parameter int unsigned ENTRIES    = 40,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 48,
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [KEY_BITS-1:0]      key_i,
  input  logic [ENTRIES-1:0]       valid_map_i,
  output logic                     rd_en_o,
  output logic [IDX_W-1:0]         rd_addr_o,
  input  logic [KEY_BITS-1:0]      rd_key_i,
  input  logic [VALUE_BITS-1:0]    rd_val_i,
  output kvlt_pkg::scan_flags_t    flags_o,
  output logic [IDX_W-1:0]         hit_idx_o,
  output logic [VALUE_BITS-1:0]    hit_val_o,
  output logic [IDX_W-1:0]         free_idx_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic                  run_q;
  logic [IDX_W-1:0]      addr_q;
  logic                  pend_q;
  logic [IDX_W-1:0]      pend_idx_q;
  logic                  done_q;
  logic                  hit_q;
  logic                  free_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [VALUE_BITS-1:0] hit_val_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic                  cmp_valid;
  logic                  cmp_hit;
  logic                  cmp_free;

  // compare the slot whose read data just came back
  assign cmp_valid = valid_map_i[pend_idx_q];
  assign cmp_hit   = pend_q && cmp_valid && (rd_key_i == key_i) && !hit_q;
  assign cmp_free  = pend_q && !cmp_valid && !free_q;

  // address walk and scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      addr_q     <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      addr_q <= '0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      pend_q     <= run_q;
      pend_idx_q <= addr_q;
      done_q     <= pend_q && !run_q;
      if (run_q) begin
        if (addr_q == LAST_IDX) begin
          run_q <= 1'b0;
        end else begin
          addr_q <= addr_q + 1'b1;
        end
      end
      if (cmp_hit) begin
        hit_q <= 1'b1;
      end
      if (cmp_free) begin
        free_q <= 1'b1;
      end
    end
  end

  // captured slot indexes and value
  always_ff @(posedge clk_i) begin
    if (cmp_hit) begin
      hit_idx_q <= pend_idx_q;
      hit_val_q <= rd_val_i;
    end
    if (cmp_free) begin
      free_idx_q <= pend_idx_q;
    end
  end

  assign rd_en_o         = run_q;
  assign rd_addr_o       = addr_q;
  assign flags_o.done    = done_q;
  assign flags_o.hit     = hit_q;
  assign flags_o.free_ok = free_q;
  assign hit_idx_o       = hit_idx_q;
  assign hit_val_o       = hit_val_q;
  assign free_idx_o      = free_idx_q;

endmodule

### rtl/key_value_leaf_table.sv
// Each request walks all ENTRIES slots, one per cycle, through the key memory
//   read port before the response is made valid.
// Request ready is held low until the response beat is taken, so a new request
//   is not accepted while one is in flight.
// Reset (rst_ni, async, active low) clears the valid bitmap and entry count;
//   key and value memories are not cleared and are only used behind valid bits.
module key_value_leaf_table #(
  parameter int unsigned ENTRIES    = 40,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kvlt_req_if.sink   req_i,
  kvlt_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  kvlt_pkg::state_e                state_q, state_d;
  logic [kvlt_pkg::MODE_W-1:0]     mode_q;
  logic [KEY_BITS-1:0]             key_q;
  logic [VALUE_BITS-1:0]           val_q;
  logic [ENTRIES-1:0]              valid_q, valid_d;
  logic [CNT_W-1:0]                count_q, count_d;

  logic                            found_q, found_d;
  logic [kvlt_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [kvlt_pkg::VALUE_W-1:0]    vout_q, vout_d;
  logic [kvlt_pkg::STAT_W-1:0]     status_q, status_d;

  logic                            req_fire;
  logic                            rsp_fire;
  logic                            wr_en;
  logic                            wr_key_en;
  logic [IDX_W-1:0]                wr_addr;

  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  logic [KEY_BITS-1:0]             rd_key;
  logic [VALUE_BITS-1:0]           rd_val;
  kvlt_pkg::scan_flags_t           scan_flags;
  logic [IDX_W-1:0]                hit_idx;
  logic [VALUE_BITS-1:0]           hit_val;
  logic [IDX_W-1:0]                free_idx;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;

  kvlt_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .key_we_i (wr_key_en),
    .waddr_i  (wr_addr),
    .wkey_i   (key_q),
    .wval_i   (val_q),
    .re_i     (rd_en),
    .raddr_i  (rd_addr),
    .rkey_o   (rd_key),
    .rval_o   (rd_val)
  );

  kvlt_scan #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (req_fire),
    .key_i       (key_q),
    .valid_map_i (valid_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_key_i    (rd_key),
    .rd_val_i    (rd_val),
    .flags_o     (scan_flags),
    .hit_idx_o   (hit_idx),
    .hit_val_o   (hit_val),
    .free_idx_o  (free_idx)
  );

  // finish a request once the scan is done: pick result, update table
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    count_d   = count_q;
    found_d   = found_q;
    slot_d    = slot_q;
    vout_d    = vout_q;
    status_d  = status_q;
    wr_en     = 1'b0;
    wr_key_en = 1'b0;
    wr_addr   = hit_idx;

    case (state_q)
      kvlt_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_d = kvlt_pkg::ST_SCAN;
        end
      end
      kvlt_pkg::ST_SCAN: begin
        if (scan_flags.done) begin
          state_d  = kvlt_pkg::ST_RESP;
          found_d  = 1'b0;
          slot_d   = '0;
          vout_d   = '0;
          status_d = kvlt_pkg::STATUS_OK;
          case (mode_q)
            kvlt_pkg::MODE_UPSERT: begin
              if (scan_flags.hit) begin
                wr_en   = 1'b1;
                found_d = 1'b1;
                slot_d  = kvlt_pkg::SLOT_W'(hit_idx);
              end else if (scan_flags.free_ok) begin
                wr_en             = 1'b1;
                wr_key_en         = 1'b1;
                wr_addr           = free_idx;
                valid_d[free_idx] = 1'b1;
                count_d           = count_q + 1'b1;
                slot_d            = kvlt_pkg::SLOT_W'(free_idx);
              end else begin
                status_d = kvlt_pkg::STATUS_FULL;
              end
            end
            kvlt_pkg::MODE_REMOVE: begin
              if (scan_flags.hit) begin
                valid_d[hit_idx] = 1'b0;
                count_d          = count_q - 1'b1;
                found_d          = 1'b1;
                slot_d           = kvlt_pkg::SLOT_W'(hit_idx);
              end else begin
                status_d = kvlt_pkg::STATUS_MISS;
              end
            end
            default: begin
              // lookup, and the unused mode code
              if (scan_flags.hit) begin
                found_d = 1'b1;
                slot_d  = kvlt_pkg::SLOT_W'(hit_idx);
                vout_d  = kvlt_pkg::VALUE_W'(hit_val);
              end else begin
                status_d = kvlt_pkg::STATUS_MISS;
              end
            end
          endcase
        end
      end
      kvlt_pkg::ST_RESP: begin
        if (rsp_fire) begin
          state_d = kvlt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kvlt_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kvlt_pkg::ST_IDLE;
      valid_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  // request capture and response payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      mode_q <= req_i.mode;
      key_q  <= req_i.key[KEY_BITS-1:0];
      val_q  <= req_i.value_in[VALUE_BITS-1:0];
    end
    found_q  <= found_d;
    slot_q   <= slot_d;
    vout_q   <= vout_d;
    status_q <= status_d;
  end

  assign req_i.ready       = (state_q == kvlt_pkg::ST_IDLE);
  assign rsp_o.valid       = (state_q == kvlt_pkg::ST_RESP);
  assign rsp_o.found       = found_q;
  assign rsp_o.slot        = slot_q;
  assign rsp_o.value_out   = vout_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_count = kvlt_pkg::COUNT_W'(count_q);

endmodule
